// ----- rtl/shix_pkg.sv -----
// ----------------------------------------------------------------------------
// shix_pkg
// Shared types and constants for the sorted hash index table: command and
// status codes, transaction payloads and the cell-to-cell link types.
// ----------------------------------------------------------------------------
package shix_pkg;

  // Default number of table positions.
  localparam int TABLE_DEPTH_DEF = 64;

  // Field widths fixed by the transaction format.
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int ENTRY_W  = 16;
  localparam int POS_W    = 6;
  localparam int HASH_W   = 16;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_KEY_BYTE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND_FIRST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_NEXT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  key_byte;
    logic [ENTRY_W-1:0] entry_number;
    logic [POS_W-1:0]   start_position;
  } item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [ENTRY_W-1:0]  matched_entry;
    logic [HASH_W-1:0]   key_hash;
  } result_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic               cmp_en;
    logic               ins_en;
    logic [HASH_W-1:0]  key_hash;
    logic [ENTRY_W-1:0] entry_number;
    logic [POS_W-1:0]   start_position;
  } cell_ctl_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic               le;
    logic               lt;
    logic [HASH_W-1:0]  hash;
    logic [ENTRY_W-1:0] entry;
  } cell_link_t;

  // Per-cell status read back by the sequencer.
  typedef struct packed {
    logic ins_here;
    logic hit_first;
    logic hit_next;
  } cell_stat_t;

endpackage

// ----- rtl/shix_in_if.sv -----
// ----------------------------------------------------------------------------
// shix_in_if
// Valid/ready channel that carries command transactions into the table.
// ----------------------------------------------------------------------------
interface shix_in_if;
  import shix_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/shix_out_if.sv -----
// ----------------------------------------------------------------------------
// shix_out_if
// Valid/ready channel that carries result transactions out of the table.
// ----------------------------------------------------------------------------
interface shix_out_if;
  import shix_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/sorted_hash_index_table.sv -----
// A command that gives a result is accepted while every cell registers its
// compare against the key hash; in the execute state, once the result
// register is free, the row is updated and the result loaded. A key byte
// needs no execute state; the block takes key bytes at one per cycle, but
// no new item until a command has left the execute state. Reset empties the
// table and clears the running hash; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sorted_hash_index_table
// Table of (key hash, entry number) pairs kept in ascending hash order in a
// row of cells, with a byte-sum running hash, sorted insert, find first,
// find next and clear.
// ----------------------------------------------------------------------------
module sorted_hash_index_table #(
  parameter int TABLE_DEPTH = shix_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  shix_in_if.sink     item,
  shix_out_if.source  result
);
  import shix_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic               state;
  logic [CW-1:0]      entry_count;
  logic [HASH_W-1:0]  running_hash;
  logic [CMD_W-1:0]   cmd;
  logic [HASH_W-1:0]  key_hash;
  logic [ENTRY_W-1:0] entry_number;

  logic               accept;
  logic               exec_fire;
  logic               table_full;
  logic               needs_exec;
  cell_ctl_t          ctl;
  cell_link_t         links [TABLE_DEPTH+1];
  cell_stat_t         stats [TABLE_DEPTH];

  logic [IW-1:0]      ins_pos;
  logic [IW-1:0]      first_pos;
  logic [IW-1:0]      next_pos;
  logic               first_hit;
  logic               next_hit;
  logic [ENTRY_W-1:0] first_entry;
  logic [ENTRY_W-1:0] next_entry;
  result_t            result_next;

  // Handshake and sequencing.
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign exec_fire  = (state == ST_EXEC) && (!result.valid || result.ready);
  assign table_full = (entry_count == CW'(TABLE_DEPTH));

  always_comb begin
    case (item.data.cmd)
      CMD_INSERT, CMD_FIND_FIRST, CMD_FIND_NEXT, CMD_CLEAR: needs_exec = 1'b1;
      default:                                              needs_exec = 1'b0;
    endcase
  end

  // Control broadcast to the cells.
  assign ctl.cmp_en         = accept;
  assign ctl.ins_en         = exec_fire && (cmd == CMD_INSERT) && !table_full;
  assign ctl.key_hash       = (state == ST_IDLE) ? running_hash : key_hash;
  assign ctl.entry_number   = entry_number;
  assign ctl.start_position = item.data.start_position;

  // The head of the row acts as a cell below every hash.
  assign links[0].le    = 1'b1;
  assign links[0].lt    = 1'b1;
  assign links[0].hash  = '0;
  assign links[0].entry = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    shix_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX       (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .count (entry_count),
      .left  (links[i]),
      .link  (links[i+1]),
      .stat  (stats[i])
    );
  end

  // Binary index of the one-hot insert point and match positions.
  always_comb begin
    ins_pos     = '0;
    first_pos   = '0;
    next_pos    = '0;
    first_hit   = 1'b0;
    next_hit    = 1'b0;
    first_entry = '0;
    next_entry  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (stats[i].ins_here) begin
        ins_pos = ins_pos | IW'(i);
      end
      if (stats[i].hit_first) begin
        first_pos   = first_pos | IW'(i);
        first_hit   = 1'b1;
        first_entry = first_entry | links[i+1].entry;
      end
      if (stats[i].hit_next) begin
        next_pos   = next_pos | IW'(i);
        next_hit   = 1'b1;
        next_entry = next_entry | links[i+1].entry;
      end
    end
  end

  // Command capture and running hash.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_hash <= '0;
    end else begin
      if (accept) begin
        case (item.data.cmd)
          CMD_KEY_BYTE: begin
            running_hash <= running_hash + HASH_W'(item.data.key_byte);
          end
          CMD_INSERT, CMD_FIND_FIRST, CMD_FIND_NEXT: begin
            running_hash <= '0;
          end
          default: begin
            running_hash <= running_hash;
          end
        endcase
        if (needs_exec) begin
          state <= ST_EXEC;
        end
      end else if (exec_fire) begin
        state <= ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd          <= item.data.cmd;
      key_hash     <= running_hash;
      entry_number <= item.data.entry_number;
    end
  end

  // Entry count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (exec_fire) begin
      if (cmd == CMD_CLEAR) begin
        entry_count <= '0;
      end else if (ctl.ins_en) begin
        entry_count <= entry_count + CW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (exec_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result contents for the command in flight.
  always_comb begin
    result_next          = '0;
    result_next.key_hash = key_hash;
    result_next.status   = STATUS_OK;
    case (cmd)
      CMD_INSERT: begin
        if (table_full) begin
          result_next.status = STATUS_FULL;
        end else begin
          result_next.position      = POS_W'(ins_pos);
          result_next.matched_entry = entry_number;
        end
      end
      CMD_FIND_FIRST: begin
        if (first_hit) begin
          result_next.position      = POS_W'(first_pos);
          result_next.matched_entry = first_entry;
        end else begin
          result_next.status = STATUS_NOT_FOUND;
        end
      end
      CMD_FIND_NEXT: begin
        if (next_hit) begin
          result_next.position      = POS_W'(next_pos);
          result_next.matched_entry = next_entry;
        end else begin
          result_next.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        result_next.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result.data <= result_next;
    end
  end

endmodule

// ----- rtl/shix_cell.sv -----
// ----------------------------------------------------------------------------
// shix_cell
// One table position: holds a hash and entry number, compares the hash with
// the key hash, and on insert keeps its value, takes the new pair, or takes its
// left neighbor's pair so that the row stays sorted.
// ----------------------------------------------------------------------------
module shix_cell #(
  parameter int TABLE_DEPTH = shix_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX       = 0
) (
  input  logic                               clk,
  input  shix_pkg::cell_ctl_t                ctl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
  input  shix_pkg::cell_link_t               left,
  output shix_pkg::cell_link_t               link,
  output shix_pkg::cell_stat_t               stat
);
  import shix_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > POS_W + 1) ? CW : POS_W + 1;

  logic [HASH_W-1:0]  hash;
  logic [ENTRY_W-1:0] entry;
  logic               le;
  logic               lt;
  logic               sel;
  logic               occupied;
  logic               eq;

  // A position holds a live pair when it lies below the entry count.
  assign occupied = (CW'(INDEX) < count);
  assign eq       = le & ~lt;

  // Compare flags, taken in the cycle the command is accepted.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt  <= occupied && (hash < ctl.key_hash);
      le  <= occupied && (hash <= ctl.key_hash);
      sel <= ((SW'(ctl.start_position) + SW'(1)) == SW'(INDEX));
    end
  end

  // Sorted insert: keep, take the new pair, or shift in from the left.
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !le) begin
      if (left.le) begin
        hash  <= ctl.key_hash;
        entry <= ctl.entry_number;
      end else begin
        hash  <= left.hash;
        entry <= left.entry;
      end
    end
  end

  assign link.le    = le;
  assign link.lt    = lt;
  assign link.hash  = hash;
  assign link.entry = entry;

  // The boundaries of the sorted prefix masks mark the insert point and the
  // first equal hash; a find-next hit needs an equal hash one past the start.
  assign stat.ins_here  = left.le & ~le;
  assign stat.hit_first = left.lt & ~lt & eq;
  assign stat.hit_next  = sel & eq;

endmodule

// ----- sim/shix_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shix_checker
// Watches the command and result channels of the sorted hash index table,
// keeps its own copy of the sorted table and running hash, and compares
// every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module shix_checker #(
  parameter int DEPTH = shix_pkg::TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  shix_in_if   items,
  shix_out_if  results,
  output int   fails,
  output int   pending
);
  import shix_pkg::*;

  // Shadow copy of the table, kept in ascending hash order.
  logic [HASH_W-1:0]  hash_mem [DEPTH];
  logic [ENTRY_W-1:0] entry_mem [DEPTH];
  int                 used;
  logic [HASH_W-1:0]  key_sum;

  // Results still owed by the block, oldest first.
  result_t            awaited_results [$];
  result_t            want;

  // Apply one accepted command to the shadow table and queue its result.
  task automatic apply_command(input item_t it);
    int                p;
    logic [HASH_W-1:0] h;
    result_t           r;
    logic              gives;
    h          = key_sum;
    r          = '0;
    r.key_hash = h;
    gives      = 1'b1;
    case (it.cmd)
      CMD_KEY_BYTE: begin
        key_sum = key_sum + HASH_W'(it.key_byte);
        gives   = 1'b0;
      end
      CMD_INSERT: begin
        key_sum = '0;
        if (used >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          // Equal hashes go after the ones already stored.
          p = 0;
          while (p < used && hash_mem[p] <= h) p++;
          for (int i = used; i > p; i--) begin
            hash_mem[i]  = hash_mem[i-1];
            entry_mem[i] = entry_mem[i-1];
          end
          hash_mem[p]     = h;
          entry_mem[p]    = it.entry_number;
          used++;
          r.status        = STATUS_OK;
          r.position      = POS_W'(p);
          r.matched_entry = it.entry_number;
        end
      end
      CMD_FIND_FIRST: begin
        key_sum  = '0;
        r.status = STATUS_NOT_FOUND;
        for (int i = 0; i < used; i++) begin
          if (hash_mem[i] == h) begin
            r.status        = STATUS_OK;
            r.position      = POS_W'(i);
            r.matched_entry = entry_mem[i];
            break;
          end else if (hash_mem[i] > h) begin
            break;
          end
        end
      end
      CMD_FIND_NEXT: begin
        // Only the position right after the start position is looked at.
        key_sum  = '0;
        p        = int'(it.start_position) + 1;
        r.status = STATUS_NOT_FOUND;
        if (p < used && hash_mem[p] == h) begin
          r.status        = STATUS_OK;
          r.position      = POS_W'(p);
          r.matched_entry = entry_mem[p];
        end
      end
      CMD_CLEAR: begin
        // The running hash survives a clear.
        used     = 0;
        r.status = STATUS_OK;
      end
      default: begin
        gives = 1'b0;
      end
    endcase
    if (gives) awaited_results.push_back(r);
  endtask

  // Compare accepted results first, then predict from the accepted command.
  always @(posedge clk) begin
    if (rst) begin
      used    = 0;
      key_sum = '0;
      fails   = 0;
      awaited_results.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with none expected: %p", results.data);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (results.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, results.data.status);
            fails++;
          end
          if (results.data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position,
                   results.data.position);
            fails++;
          end
          if (results.data.matched_entry !== want.matched_entry) begin
            $error("matched_entry: expected 0x%04h, got 0x%04h", want.matched_entry,
                   results.data.matched_entry);
            fails++;
          end
          if (results.data.key_hash !== want.key_hash) begin
            $error("key_hash: expected 0x%04h, got 0x%04h", want.key_hash,
                   results.data.key_hash);
            fails++;
          end
        end
      end
      if (items.valid && items.ready) apply_command(items.data);
    end
    pending = awaited_results.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command transactions into the sorted hash index table: a directed
// run over edge cases, long keys that reach every hash bit and wrap the sum,
// random key and lookup sequences, table fills and a long result stall.
// ----------------------------------------------------------------------------
module testbench;
  import shix_pkg::*;

  localparam int               HOLD_CYCLES   = 200;
  localparam int               STALL_LIMIT   = 2000;
  localparam int               POOL_SIZE     = 6;
  localparam int               RANDOM_ITEMS  = 950;
  localparam logic [CMD_W-1:0] CMD_RSVD_LO   = CMD_CLEAR + 3'd1;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI   = {CMD_W{1'b1}};

  logic clk;
  logic rst;
  logic item_taken;
  logic hold_req;
  logic hold_seen;
  logic no_idle;
  int   fail_count;
  int   awaited_count;
  int   idle_cycles;
  int   sent;
  int   shadow_used;
  int   base;

  logic [HASH_W-1:0] hash_pool [POOL_SIZE];

  shix_in_if  item_ch ();
  shix_out_if result_ch ();

  sorted_hash_index_table u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  shix_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .fails   (fail_count),
    .pending (awaited_count)
  );

  // Clock, 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Command acceptance, seen by the sender at the following falling edge.
  always @(posedge clk) begin
    item_taken <= item_ch.valid && item_ch.ready;
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, or one long hold-off each time the
  // request toggles.
  initial begin
    result_ch.ready = 1'b0;
    hold_seen       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req !== hold_seen) begin
        hold_seen       = hold_req;
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_ch.ready = no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  // Offer one command transaction and wait until it is taken.
  task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] kb,
                               input logic [ENTRY_W-1:0] en,
                               input logic [POS_W-1:0] sp);
    if (!no_idle && $urandom_range(99) < 7) begin
      item_ch.valid = 1'b0;
      item_ch.data  = item_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item_ch.data  = '{cmd: cmd, key_byte: kb, entry_number: en, start_position: sp};
    item_ch.valid = 1'b1;
    do @(negedge clk); while (!item_taken);
    sent++;
    // Rough fill level, used to aim find-next at live positions.
    if (cmd == CMD_INSERT && shadow_used < TABLE_DEPTH_DEF) shadow_used++;
    if (cmd == CMD_CLEAR) shadow_used = 0;
  endtask

  // Send key bytes whose sum is the given hash, with a few zero bytes mixed in.
  task automatic spell_hash(input int target);
    int rem;
    int b;
    rem = target;
    while (rem > 0) begin
      b = $urandom_range(1, (rem > 255) ? 255 : rem);
      if ($urandom_range(9) == 0) begin
        offer_command(CMD_KEY_BYTE, '0, 16'($urandom), 6'($urandom));
      end
      offer_command(CMD_KEY_BYTE, 8'(b), 16'($urandom), 6'($urandom));
      rem -= b;
    end
  endtask

  // Pick a fresh set of hashes so that keys collide often.
  task automatic refresh_pool();
    hash_pool[0] = '0;
    for (int i = 1; i < POOL_SIZE; i++) hash_pool[i] = 16'($urandom_range(1, 700));
  endtask

  // One random step: mostly a key then a command, sometimes plain noise.
  task automatic mixed_command();
    int sel;
    logic [POS_W-1:0] sp;
    sel = $urandom_range(99);
    if (sel < 12) begin
      offer_command(CMD_W'($urandom_range(0, CMD_RSVD_HI)), 8'($urandom),
                    16'($urandom), 6'($urandom));
    end else begin
      spell_hash(hash_pool[$urandom_range(0, POOL_SIZE - 1)]);
      sel = $urandom_range(99);
      if (shadow_used > 0 && $urandom_range(4) != 0) begin
        sp = POS_W'($urandom_range(0, shadow_used - 1));
      end else begin
        sp = 6'($urandom);
      end
      if (sel < 40) begin
        offer_command(CMD_INSERT, 8'($urandom), 16'($urandom), 6'($urandom));
      end else if (sel < 65) begin
        offer_command(CMD_FIND_FIRST, 8'($urandom), 16'($urandom), 6'($urandom));
      end else if (sel < 88) begin
        offer_command(CMD_FIND_NEXT, 8'($urandom), 16'($urandom), sp);
      end else if (sel < 93) begin
        offer_command(CMD_CLEAR, 8'($urandom), 16'($urandom), 6'($urandom));
      end else begin
        offer_command(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), 8'($urandom),
                      16'($urandom), 6'($urandom));
      end
    end
  endtask

  // Fill the table past its depth, probe it, then empty it.
  task automatic fill_table();
    offer_command(CMD_CLEAR, '0, '0, '0);
    refresh_pool();
    repeat (TABLE_DEPTH_DEF + 3) begin
      spell_hash(hash_pool[$urandom_range(0, POOL_SIZE - 1)]);
      offer_command(CMD_INSERT, 8'($urandom), 16'($urandom), 6'($urandom));
    end
    repeat (8) begin
      spell_hash(hash_pool[$urandom_range(0, POOL_SIZE - 1)]);
      if ($urandom_range(1) == 0) begin
        offer_command(CMD_FIND_FIRST, '0, '0, '0);
      end else begin
        offer_command(CMD_FIND_NEXT, '0, '0, 6'($urandom_range(0, TABLE_DEPTH_DEF - 1)));
      end
    end
    offer_command(CMD_CLEAR, '0, '0, '0);
  endtask

  // Stimulus and verdict.
  initial begin
    rst           = 1'b1;
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    sent          = 0;
    shadow_used   = 0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty lookups, equal hashes, find-next edges, reserved codes.
    offer_command(CMD_FIND_FIRST, '0, '0, '0);
    offer_command(CMD_FIND_NEXT, '0, '0, 6'h3F);
    offer_command(CMD_KEY_BYTE, 8'hFF, '0, '0);
    offer_command(CMD_KEY_BYTE, 8'hFF, 16'hFFFF, 6'h3F);
    offer_command(CMD_INSERT, '0, 16'hFFFF, '0);
    offer_command(CMD_INSERT, '0, 16'h0000, 6'h3F);
    offer_command(CMD_KEY_BYTE, 8'h00, '0, '0);
    offer_command(CMD_INSERT, 8'hFF, 16'h1234, '0);
    offer_command(CMD_FIND_FIRST, '0, '0, '0);
    offer_command(CMD_FIND_NEXT, '0, '0, 6'd0);
    offer_command(CMD_FIND_NEXT, '0, '0, 6'd1);
    offer_command(CMD_KEY_BYTE, 8'hFF, '0, '0);
    offer_command(CMD_KEY_BYTE, 8'hFF, '0, '0);
    offer_command(CMD_FIND_NEXT, '0, '0, 6'd1);
    offer_command(CMD_FIND_NEXT, '0, '0, 6'd2);
    offer_command(CMD_KEY_BYTE, 8'h80, '0, '0);
    offer_command(CMD_RSVD_LO, 8'hFF, 16'hFFFF, 6'h3F);
    offer_command(CMD_RSVD_LO + 3'd1, 8'h55, 16'hAAAA, 6'h2A);
    offer_command(CMD_RSVD_HI, 8'h00, 16'h0000, 6'h00);
    offer_command(CMD_KEY_BYTE, 8'h7F, '0, '0);
    offer_command(CMD_CLEAR, '0, '0, '0);
    offer_command(CMD_INSERT, '0, 16'hAAAA, '0);
    offer_command(CMD_FIND_FIRST, '0, '0, '0);

    // Long key: every hash bit set, shown by a clear that keeps the running
    // hash, then one more byte wraps the sum.
    offer_command(CMD_CLEAR, '0, '0, '0);
    repeat (257) offer_command(CMD_KEY_BYTE, 8'hFF, 16'($urandom), 6'($urandom));
    offer_command(CMD_CLEAR, '0, '0, '0);
    offer_command(CMD_KEY_BYTE, 8'hFF, 16'($urandom), 6'($urandom));
    offer_command(CMD_INSERT, '0, 16'($urandom), '0);

    // Random sequences with stalls on both sides.
    base = sent;
    refresh_pool();
    while (sent - base < 300) mixed_command();

    // Long result hold-off while commands keep coming, then drain.
    hold_req = ~hold_req;
    repeat (30) mixed_command();
    item_ch.valid = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    // A stretch without any idling.
    no_idle = 1'b1;
    fill_table();
    repeat (60) mixed_command();
    no_idle = 1'b0;

    refresh_pool();
    while (sent - base < RANDOM_ITEMS) mixed_command();

    // Drain and give the verdict.
    item_ch.valid = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sorted_hash_index_table.f -----
rtl/shix_pkg.sv
rtl/shix_in_if.sv
rtl/shix_out_if.sv
rtl/shix_cell.sv
rtl/sorted_hash_index_table.sv
sim/shix_checker.sv
sim/testbench.sv
